// ===== sv/ldr_pkg.sv =====
// Package for the lamp dimmer ramp controller: codes, widths and reset values.
package ldr_pkg;

  localparam int unsigned LevelW   = 10;
  localparam int unsigned WakeCntW = 16;
  localparam int unsigned AutoCntW = 11;
  localparam int unsigned OpW      = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [LevelW-1:0]   LevelFull       = 10'h3FF;
  localparam logic [LevelW-1:0]   AutoOffReset    = 10'd120;
  localparam logic [WakeCntW-1:0] WakeStepReset   = 16'd700;
  localparam logic [LevelW-1:0]   DimFloorReset   = 10'd150;

  typedef enum logic [OpW-1:0] {
    OP_MS_TICK  = 3'd0,
    OP_MIN_TICK = 3'd1,
    OP_ON       = 3'd2,
    OP_OFF      = 3'd3,
    OP_SET      = 3'd4,
    OP_WAKE     = 3'd5,
    OP_DIM      = 3'd6
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AUTO_OFF  = 2'd0,
    CFG_WAKE_STEP = 2'd1,
    CFG_DIM_FLOOR = 2'd2
  } cfg_idx_t;

  function automatic logic [LevelW-1:0] level_up(input logic [LevelW-1:0] v);
    level_up = (v == LevelFull) ? LevelFull : v + LevelW'(1);
  endfunction

endpackage

// ===== sv/lamp_dimmer_ramp_controller.sv =====
// Lamp dimmer ramp controller: ramp state, config registers and result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per transfer:
//   ms tick, minute tick, on, off, set level (in_new_level), wake, dim loop.
//   Every input transfer yields exactly one result transfer on the output
//   channel (out_valid/out_ready) with the level and lamp enable after the
//   update.
//   State and the result register update on the edge that takes the input.
//   Throughput is one item per cycle while the receiver keeps up; the single
//   result register is refilled in the same cycle it is drained.
//   When the receiver stalls with a result pending, in_ready drops until that
//   result is taken; the pending result holds.
//   Config writes (cfg_we, cfg_idx, cfg_wdata) are registered; index 3
//   is ignored.
//   Synchronous reset clears all ramp state and the output valid and loads
//   auto_off_minutes=120, wake_step_ticks=700, dim_floor=150.
module lamp_dimmer_ramp_controller (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ldr_pkg::OpW-1:0]      in_operation,
  input  logic [ldr_pkg::LevelW-1:0]   in_new_level,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ldr_pkg::LevelW-1:0]   out_level,
  output logic                         out_lamp_on,
  input  logic                         cfg_we,
  input  logic [ldr_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [ldr_pkg::CfgDataW-1:0] cfg_wdata
);
  import ldr_pkg::*;

  logic [LevelW-1:0]   auto_off_r, dim_floor_r;
  logic [WakeCntW-1:0] wake_step_r;

  logic enabled_r, was_en_r, wake_r, dim_r, soft_start_r, soft_off_r, rising_r;
  logic enabled_nxt, was_en_nxt, wake_nxt, dim_nxt, soft_start_nxt, soft_off_nxt;
  logic rising_nxt;
  logic [LevelW-1:0]   level_r, level_nxt;
  logic [WakeCntW-1:0] wake_cnt_r, wake_cnt_nxt;
  logic [AutoCntW-1:0] auto_cnt_r, auto_cnt_nxt;

  logic              out_valid_r;
  logic [LevelW-1:0] out_level_r;
  logic              out_lamp_on_r;
  logic              in_xfer;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_lamp_on = out_lamp_on_r;

  always_comb begin
    enabled_nxt    = enabled_r;
    was_en_nxt     = was_en_r;
    wake_nxt       = wake_r;
    dim_nxt        = dim_r;
    soft_start_nxt = soft_start_r;
    soft_off_nxt   = soft_off_r;
    rising_nxt     = rising_r;
    level_nxt      = level_r;
    wake_cnt_nxt   = wake_cnt_r;
    auto_cnt_nxt   = auto_cnt_r;
    case (in_operation)
      OP_MS_TICK: begin
        if (wake_r && level_r != LevelFull && enabled_r) begin
          soft_start_nxt = 1'b0;
          dim_nxt        = 1'b0;
          if (wake_cnt_r == wake_step_r) begin
            level_nxt    = level_up(level_r);
            wake_cnt_nxt = '0;
          end else begin
            wake_cnt_nxt = wake_cnt_r + WakeCntW'(1);
          end
        end else begin
          wake_nxt = 1'b0;
          if (enabled_r) begin
            if (!was_en_r && !dim_r) soft_start_nxt = 1'b1;
            else if (!was_en_r && dim_r) level_nxt = dim_floor_r;
            was_en_nxt = 1'b1;
            if (soft_start_nxt && !dim_r) begin
              level_nxt = level_up(level_nxt);
              if (level_nxt == LevelFull) soft_start_nxt = 1'b0;
            end
            if (dim_r) begin
              soft_start_nxt = 1'b0;
              if (rising_r) begin
                level_nxt = level_up(level_nxt);
                if (level_nxt == LevelFull) rising_nxt = 1'b0;
              end else if (level_nxt == '0) begin
                rising_nxt = 1'b1;
              end else begin
                level_nxt = level_nxt - LevelW'(1);
                if (level_nxt < dim_floor_r) rising_nxt = 1'b1;
              end
            end
          end else begin
            if (was_en_r) begin
              soft_off_nxt = 1'b1;
              was_en_nxt   = 1'b0;
            end
            if (soft_off_nxt) begin
              if (level_r == '0) begin
                enabled_nxt    = 1'b0;
                was_en_nxt     = 1'b0;
                wake_nxt       = 1'b0;
                dim_nxt        = 1'b0;
                soft_start_nxt = 1'b0;
                soft_off_nxt   = 1'b0;
                rising_nxt     = 1'b0;
              end else begin
                level_nxt = level_r - LevelW'(1);
              end
            end
          end
        end
      end
      OP_MIN_TICK: begin
        if (enabled_r) begin
          auto_cnt_nxt = auto_cnt_r + AutoCntW'(1);
          if (auto_cnt_r == {1'b0, auto_off_r}) enabled_nxt = 1'b0;
        end else begin
          auto_cnt_nxt = '0;
        end
      end
      OP_ON: begin
        if (!enabled_r) begin
          enabled_nxt = 1'b1;
          dim_nxt     = 1'b0;
          rising_nxt  = 1'b1;
        end
      end
      OP_OFF:  enabled_nxt = 1'b0;
      OP_SET: begin
        soft_start_nxt = 1'b0;
        wake_nxt       = 1'b0;
        level_nxt      = in_new_level;
      end
      OP_WAKE: wake_nxt = 1'b1;
      OP_DIM:  dim_nxt  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_off_r  <= AutoOffReset;
      wake_step_r <= WakeStepReset;
      dim_floor_r <= DimFloorReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_AUTO_OFF:  auto_off_r  <= cfg_wdata[LevelW-1:0];
        CFG_WAKE_STEP: wake_step_r <= cfg_wdata[WakeCntW-1:0];
        CFG_DIM_FLOOR: dim_floor_r <= cfg_wdata[LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b0;
      was_en_r     <= 1'b0;
      wake_r       <= 1'b0;
      dim_r        <= 1'b0;
      soft_start_r <= 1'b0;
      soft_off_r   <= 1'b0;
      rising_r     <= 1'b0;
      level_r      <= '0;
      wake_cnt_r   <= '0;
      auto_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        enabled_r    <= enabled_nxt;
        was_en_r     <= was_en_nxt;
        wake_r       <= wake_nxt;
        dim_r        <= dim_nxt;
        soft_start_r <= soft_start_nxt;
        soft_off_r   <= soft_off_nxt;
        rising_r     <= rising_nxt;
        level_r      <= level_nxt;
        wake_cnt_r   <= wake_cnt_nxt;
        auto_cnt_r   <= auto_cnt_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_level_r   <= level_nxt;
      out_lamp_on_r <= enabled_nxt;
    end
  end

endmodule

// ===== sv/ldr_checker.sv =====
// Port-level assertions for the lamp dimmer ramp controller, bound to the top level.
module ldr_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [ldr_pkg::OpW-1:0]      in_operation,
  input logic [ldr_pkg::LevelW-1:0]   in_new_level,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ldr_pkg::LevelW-1:0]   out_level,
  input logic                         out_lamp_on
);
  import ldr_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_lamp_on))
    else $error("stalled result changed");

  a_off_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_OFF |=> out_valid && !out_lamp_on)
    else $error("off transfer did not report lamp off");

  a_set_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_SET
      |=> out_valid && out_level == $past(in_new_level))
    else $error("set level transfer returned wrong level");

endmodule

bind lamp_dimmer_ramp_controller ldr_checker u_ldr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_operation (in_operation),
  .in_new_level (in_new_level),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_level    (out_level),
  .out_lamp_on  (out_lamp_on)
);
